@@ rtl/core/dspm_pkg.sv @@
// Shared types and constants for the dot-star pattern matcher.
package dspm_pkg;

    localparam int MAX_TOKENS_DEF = 16;
    localparam int TOKEN_LIMIT    = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        CFG_TOKEN_LO  = 3'd0,
        CFG_TOKEN_HI  = 3'd1,
        CFG_STAR_MASK = 3'd2,
        CFG_ANY_MASK  = 3'd3,
        CFG_COUNT     = 3'd4
    } t_cfg_index;

    // What the back end does with an item.
    typedef enum logic [1:0] {
        KIND_CONT  = 2'd0,   // continue from stored positions
        KIND_START = 2'd1,   // restart at pattern start before the byte
        KIND_EMPTY = 2'd2    // whole empty string, no byte step
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] text_byte;
        logic       done;      // final verdict, state returns to start
    } t_item;

    typedef struct packed {
        logic [8*TOKEN_LIMIT-1:0] token_bytes;
        logic [TOKEN_LIMIT-1:0]   star_mask;
        logic [TOKEN_LIMIT-1:0]   any_mask;
        logic [4:0]               token_count;
    } t_pattern;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] count;
    } t_q_status;

endpackage

@@ rtl/core/dspm_front.sv @@
// Front end: accepts text requests, classifies them and queues them for the back end.
module dspm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] text_byte
    input  logic [1:0]          s_axis_tuser,   // [0] first_of_text, [1] empty_text
    input  logic                s_axis_tlast,
    input  logic                i_pop,
    output dspm_pkg::t_item     o_head,
    output dspm_pkg::t_q_status o_status
);
    import dspm_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item              r_slot [QUEUE_DEPTH];
    logic [PW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [1:0]         r_count,  n_count;
    t_item              w_item;
    logic               w_push;

    always_comb begin
        w_item.text_byte = s_axis_tdata;
        w_item.done      = s_axis_tlast | s_axis_tuser[1];
        if (s_axis_tuser[1]) begin
            w_item.kind = KIND_EMPTY;
        end else if (s_axis_tuser[0]) begin
            w_item.kind = KIND_START;
        end else begin
            w_item.kind = KIND_CONT;
        end
    end

    assign s_axis_tready = (r_count != 2'(QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid & s_axis_tready;

    always_comb begin
        n_wr_ptr = w_push ? PW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? PW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = 2'(r_count + {1'b0, w_push} - {1'b0, i_pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_item;
        end
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_status.count = r_count;

endmodule

@@ rtl/core/dspm_back.sv @@
// Back end: advances the active position set one byte per non-empty item and holds the result register.
module dspm_back #(
    parameter int MAX_TOKENS = dspm_pkg::MAX_TOKENS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dspm_pkg::t_pattern  i_pattern,
    input  dspm_pkg::t_item     i_head,
    input  logic                i_q_empty,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [0] full_match, [7:1] zero
    output logic                m_axis_tlast
);
    import dspm_pkg::*;

    localparam int NW = $clog2(MAX_TOKENS + 1);

    logic [MAX_TOKENS:0] r_active, n_active;
    logic                r_m_valid;
    logic                r_match;
    logic                r_done;
    logic [NW-1:0]       w_n;
    logic [MAX_TOKENS:0] w_cur;
    logic [MAX_TOKENS:0] w_step;
    logic [MAX_TOKENS:0] w_next;
    logic                w_match;

    assign w_n = (i_pattern.token_count > 5'(MAX_TOKENS)) ? NW'(MAX_TOKENS)
                                                          : NW'(i_pattern.token_count);

    always_comb begin
        w_cur = (i_head.kind == KIND_CONT) ? r_active : (MAX_TOKENS+1)'(1);
        // epsilon closure: a starred position also reaches the one after it
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if ((i < int'(w_n)) && w_cur[i] && i_pattern.star_mask[i]) begin
                w_cur[i+1] = 1'b1;
            end
        end
        w_step = '0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if ((i < int'(w_n)) && w_cur[i] &&
                (i_pattern.any_mask[i] ||
                 (i_pattern.token_bytes[8*i +: 8] == i_head.text_byte))) begin
                if (i_pattern.star_mask[i]) begin
                    w_step[i] = 1'b1;
                end else begin
                    w_step[i+1] = 1'b1;
                end
            end
        end
        w_next = w_step;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if ((i < int'(w_n)) && w_next[i] && i_pattern.star_mask[i]) begin
                w_next[i+1] = 1'b1;
            end
        end
        w_match = (i_head.kind == KIND_EMPTY) ? w_cur[w_n] : w_next[w_n];
    end

    assign o_pop    = !i_q_empty && (!r_m_valid || m_axis_tready);
    assign n_active = i_head.done ? (MAX_TOKENS+1)'(1) : w_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= (MAX_TOKENS+1)'(1);
            r_m_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= n_active;
            end
            if (o_pop) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_match <= w_match;
            r_done  <= i_head.done;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_match};
    assign m_axis_tlast  = r_done;

endmodule

@@ rtl/core/dot_star_pattern_matcher_core.sv @@
// Top level of the dot-star pattern matcher: configuration registers, front and back ends.
//
//  Channel  Dir  Handshake                 Payload
//  s_axis   in   s_axis_tvalid/tready      tdata text_byte, tuser {empty,first}, tlast
//  m_axis   out  m_axis_tvalid/tready      tdata[0] full_match, tlast text_done
//  cfg      in   i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One text byte per cycle sustained while m_axis_tready is high; each request is held
//  in the two-entry queue and then in the result register before its result appears.
//  The position update, with closure chains over 16 positions by default, is combinational.
//  Synchronous active-low reset: queue and result register empty, start position active,
//  pattern registers cleared. Configuration is always ready.
//  A stalled result stops the back end only; the front end keeps filling the queue.
module dot_star_pattern_matcher_core #(
    parameter int MAX_TOKENS = dspm_pkg::MAX_TOKENS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic [1:0]  s_axis_tuser,   // [0] first_of_text, [1] empty_text
    input  logic        s_axis_tlast,   // last_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] full_match, [7:1] zero
    output logic        m_axis_tlast,   // text_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import dspm_pkg::*;

    t_pattern  r_pattern;
    t_item     w_head;
    t_q_status w_q_status;
    logic      w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TOKEN_LO:  r_pattern.token_bytes[63:0]   <= i_cfg_data;
                CFG_TOKEN_HI:  r_pattern.token_bytes[127:64] <= i_cfg_data;
                CFG_STAR_MASK: r_pattern.star_mask           <= i_cfg_data[15:0];
                CFG_ANY_MASK:  r_pattern.any_mask            <= i_cfg_data[15:0];
                CFG_COUNT:     r_pattern.token_count         <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    dspm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_pop         (w_pop),
        .o_head        (w_head),
        .o_status      (w_q_status)
    );

    dspm_back #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pattern     (r_pattern),
        .i_head        (w_head),
        .i_q_empty     (w_q_status.empty),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= 2'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_pop)
        else $error("result overwritten while stalled");

    a_accept_then_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !w_q_status.empty)
        else $error("accepted request not queued");

endmodule

@@ tb/dspm_match_checker.sv @@
// Verdict checker for the dot-star pattern matcher: tracks pattern and positions, compares results.
module dspm_match_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [7:0]  i_s_data,    // [7:0] text_byte
    input  logic [1:0]  i_s_user,    // [0] first_of_text, [1] empty_text
    input  logic        i_s_last,    // last_of_text
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [7:0]  i_m_data,    // [0] full_match
    input  logic        i_m_last,    // text_done
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dspm_pkg::*;

    typedef struct packed {
        logic full_match;
        logic text_done;
    } t_verdict;

    logic [63:0] lit_lo;
    logic [63:0] lit_hi;
    logic [15:0] star_bits;
    logic [15:0] dot_bits;
    logic [4:0]  count_reg;
    logic [16:0] live_set;     // positions reached, stored after closure
    t_verdict    verdict_q[$];
    t_verdict    want;
    t_verdict    got;

    function automatic int used_tokens();
        return (count_reg > MAX_TOKENS_DEF) ? MAX_TOKENS_DEF : int'(count_reg);
    endfunction

    // Starred tokens can be skipped: chain each active starred position upward.
    function automatic logic [16:0] close_stars(logic [16:0] set);
        int n;
        int i;
        n = used_tokens();
        for (i = 0; i < n; i++)
            if (set[i] && star_bits[i]) set[i+1] = 1'b1;
        return set;
    endfunction

    function automatic logic [7:0] literal_of(int i);
        return (i < 8) ? lit_lo[8*i +: 8] : lit_hi[8*(i-8) +: 8];
    endfunction

    function automatic t_verdict advance_positions(logic [7:0] b, logic first, logic last,
                                                   logic empty);
        t_verdict    v;
        logic [16:0] cur;
        logic [16:0] nxt;
        int          n;
        int          i;
        n = used_tokens();
        if (empty) begin
            cur = close_stars(17'd1);
            v.full_match = cur[n];
            v.text_done = 1'b1;
            live_set = 17'd1;
            return v;
        end
        cur = close_stars(first ? 17'd1 : live_set);
        nxt = '0;
        for (i = 0; i < n; i++) begin
            if (cur[i] && (dot_bits[i] || literal_of(i) == b)) begin
                if (star_bits[i]) nxt[i] = 1'b1;
                else nxt[i+1] = 1'b1;
            end
        end
        nxt = close_stars(nxt);
        v.full_match = nxt[n];
        v.text_done = last;
        live_set = last ? 17'd1 : nxt;
        return v;
    endfunction

    function automatic void report_failure(string msg);
        o_errors = o_errors + 1;
        if (o_errors <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lit_lo = '0;
            lit_hi = '0;
            star_bits = '0;
            dot_bits = '0;
            count_reg = '0;
            live_set = 17'd1;
            verdict_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOKEN_LO:  lit_lo = i_cfg_data;
                    CFG_TOKEN_HI:  lit_hi = i_cfg_data;
                    CFG_STAR_MASK: star_bits = i_cfg_data[15:0];
                    CFG_ANY_MASK:  dot_bits = i_cfg_data[15:0];
                    CFG_COUNT:     count_reg = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                got.full_match = i_m_data[0];
                got.text_done = i_m_last;
                if (verdict_q.size() == 0) begin
                    report_failure($sformatf("result with no request pending: full_match=%0b text_done=%0b",
                                             got.full_match, got.text_done));
                end else begin
                    want = verdict_q.pop_front();
                    if (want.full_match !== got.full_match)
                        report_failure($sformatf("full_match: expected %0b, got %0b",
                                                 want.full_match, got.full_match));
                    if (want.text_done !== got.text_done)
                        report_failure($sformatf("text_done: expected %0b, got %0b",
                                                 want.text_done, got.text_done));
                end
            end
            if (i_s_valid && i_s_ready)
                verdict_q.insert(verdict_q.size(),
                                 advance_positions(i_s_data, i_s_user[0], i_s_last,
                                                   i_s_user[1]));
        end
        o_pending = verdict_q.size();
    end

endmodule

@@ tb/tb_dot_star_pattern_matcher_core.sv @@
// Testbench top for the dot-star pattern matcher: pattern loads, text stimulus and verdict.
module tb_dot_star_pattern_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dspm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] text_byte
    logic [1:0]  s_axis_tuser;    // [0] first_of_text, [1] empty_text
    logic        s_axis_tlast;    // last_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;    // [0] full_match
    logic        m_axis_tlast;    // text_done
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int          fail_count;
    int          open_verdicts;
    int          quiet_cycles;
    int          sent;
    bit          gaps_on;
    bit          stalls_on;

    // pattern currently loaded, and the byte alphabet its literals come from
    logic [7:0]  tok_byte[16];
    logic [15:0] tok_star;
    logic [15:0] tok_dot;
    logic [4:0]  tok_cnt;
    logic [7:0]  alpha[4];
    logic [7:0]  text_q[$];

    dot_star_pattern_matcher_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    dspm_match_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .i_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser),
        .i_s_last    (s_axis_tlast),
        .i_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .i_m_data    (m_axis_tdata),
        .i_m_last    (m_axis_tlast),
        .o_errors    (fail_count),
        .o_pending   (open_verdicts)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !(stalls_on && $urandom_range(99) < 36);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 2000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                             input logic empty);
        while (gaps_on && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= {empty, first};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Empty text goes out as one empty-string request with junk in the ignored fields.
    task automatic send_text(input bit mark_first, input bit mark_last);
        int i;
        if (text_q.size() == 0) begin
            send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'b1);
        end else begin
            for (i = 0; i < text_q.size(); i++)
                send_item(text_q[i], mark_first && i == 0,
                          mark_last && i == text_q.size() - 1, 1'b0);
        end
    endtask

    task automatic say(input string s, input bit mark_first);
        int i;
        text_q.delete();
        for (i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
        send_text(mark_first, 1'b1);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [63:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Upper data bits beyond each register's width carry junk.
    task automatic load_pattern();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] junk;
        int          i;
        for (i = 0; i < 8; i++) begin
            lo[8*i +: 8] = tok_byte[i];
            hi[8*i +: 8] = tok_byte[i+8];
        end
        junk = {$urandom, $urandom};
        cfg_write(CFG_TOKEN_LO, lo);
        cfg_write(CFG_TOKEN_HI, hi);
        cfg_write(CFG_STAR_MASK, {junk[63:16], tok_star});
        cfg_write(CFG_ANY_MASK, {junk[63:16], tok_dot});
        cfg_write(CFG_COUNT, {junk[63:5], tok_cnt});
        i_cfg_valid <= 1'b0;
    endtask

    // Drain: stop sending, wait for every verdict, resume on a rising edge.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (open_verdicts != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        return ($urandom_range(99) < 60) ? alpha[$urandom_range(3)] : 8'($urandom_range(255));
    endfunction

    initial begin
        int         p;
        int         i;
        int         n;
        int         reps;
        int         pos;
        int         target;
        int         pick;
        logic [7:0] b;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TOKEN_LO;
        i_cfg_data = '0;
        sent = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern straight out of reset: only the empty string matches.
        say("", 1'b0);
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1, 1'b0);    // dead text stays unmatched
        settle();

        // Oversized count clamps to sixteen starred dots: everything matches.
        for (i = 0; i < 16; i++) tok_byte[i] = 8'hFF;
        tok_star = 16'hFFFF;
        tok_dot = 16'hFFFF;
        tok_cnt = 5'd31;
        load_pattern();
        say("", 1'b1);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        settle();

        // 'a', dot, literal '.' starred, literal '*'; star mask bits at and above count set, dot bits 12-15 too.
        for (i = 0; i < 16; i++) tok_byte[i] = 8'($urandom_range(255));
        tok_byte[0] = 8'h61;
        tok_byte[2] = 8'h2E;
        tok_byte[3] = 8'h2A;
        tok_star = 16'hFFF4;
        tok_dot = 16'hF002;
        tok_cnt = 5'd4;
        load_pattern();
        say("ax*", 1'b1);
        say("a..*", 1'b0);                      // fresh start after the previous last
        say("ab", 1'b1);
        say("ba*", 1'b1);
        say("", 1'b0);
        send_item(8'h61, 1'b1, 1'b0, 1'b0);
        send_item(8'h78, 1'b0, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0, 1'b0);     // restart mid string
        send_item(8'h71, 1'b0, 1'b0, 1'b0);
        send_item(8'h2A, 1'b0, 1'b1, 1'b0);
        settle();

        for (p = 0; p < 6; p++) begin
            gaps_on = (p != 2);
            stalls_on = (p != 2);
            for (i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(255));
            for (i = 0; i < 16; i++) tok_byte[i] = alpha[$urandom_range(3)];
            tok_star = 16'($urandom);
            tok_dot = 16'($urandom & $urandom);
            case (p)
                0: tok_cnt = 5'd16;
                1: tok_cnt = 5'd1;
                3: tok_cnt = 5'($urandom_range(31, 17));
                default: tok_cnt = 5'($urandom_range(16));
            endcase
            load_pattern();
            n = (tok_cnt > 16) ? 16 : int'(tok_cnt);
            target = sent + 200;
            while (sent < target) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // text built to match the pattern, sometimes broken by one edit
                    text_q.delete();
                    for (i = 0; i < n; i++) begin
                        reps = tok_star[i] ? $urandom_range(3) : 1;
                        repeat (reps)
                            text_q.insert(text_q.size(),
                                          tok_dot[i] ? pick_byte() : tok_byte[i]);
                    end
                    if ($urandom_range(99) < 30) begin
                        pos = $urandom_range(text_q.size());
                        b = pick_byte();
                        case ($urandom_range(2))
                            0: text_q.insert(pos, b);
                            1: if (pos < text_q.size()) text_q.delete(pos);
                            default: if (pos < text_q.size()) text_q[pos] = b;
                        endcase
                    end
                    send_text($urandom_range(99) < 80, $urandom_range(99) < 90);
                end else if (pick < 80) begin
                    send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'b1);
                end else begin
                    send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'b0);
                end
            end
            settle();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && open_verdicts == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ dot_star_pattern_matcher_core.f @@
rtl/core/dspm_pkg.sv
rtl/core/dspm_front.sv
rtl/core/dspm_back.sv
rtl/core/dot_star_pattern_matcher_core.sv
tb/dspm_match_checker.sv
tb/tb_dot_star_pattern_matcher_core.sv
